@@ hw/rtl/mbtcp_rr_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus TCP register responder package
// Shared types, protocol constants and microcode definitions.
// ----------------------------------------------------------------------------
`default_nettype none

package mbtcp_rr_pkg;

    // Frame store and telemetry bank geometry.
    localparam int KEPT_BYTES      = 12;
    localparam int KEPT_IDX_W      = 4;
    localparam int MIN_FRAME_BYTES = 8;
    localparam int TELE_WORDS      = 8;
    localparam int TELE_IDX_W      = 3;
    localparam int READ_ADDR_W     = 17;

    // Protocol constants.
    localparam logic [7:0]  FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0]  FC_WRITE_SINGLE  = 8'h06;
    localparam logic [7:0]  FC_EXC_READ      = 8'h83;
    localparam logic [7:0]  FC_EXC_WRITE     = 8'h86;
    localparam logic [7:0]  FC_EXC_FLAG      = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
    localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [7:0]  EXC_ILLEGAL_DATA = 8'h03;
    localparam logic [15:0] READ_COUNT_LIMIT = 16'd20;
    localparam logic [15:0] MIN_DATA_LEN     = 16'd4;
    localparam logic [7:0]  LEN_EXCEPTION    = 8'd3;
    localparam logic [7:0]  LEN_WRITE        = 8'd6;
    localparam logic [7:0]  LEN_READ_BASE    = 8'd3;

    // Configuration register indexes and reset values.
    localparam logic [0:0]  CFG_UNIT_ADDRESS     = 1'b0;
    localparam logic [0:0]  CFG_SETPOINT_ADDRESS = 1'b1;
    localparam logic [7:0]  UNIT_ADDRESS_RESET   = 8'd1;
    localparam logic [15:0] SETPOINT_RESET       = 16'h0010;

    // Microcode step addresses.
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step UC_TID_HI      = 5'd0;
    localparam t_step UC_TID_LO      = 5'd1;
    localparam t_step UC_PID_HI      = 5'd2;
    localparam t_step UC_PID_LO      = 5'd3;
    localparam t_step UC_LEN_HI      = 5'd4;
    localparam t_step UC_LEN_LO      = 5'd5;
    localparam t_step UC_UNIT        = 5'd6;
    localparam t_step UC_EXC_FC      = 5'd7;
    localparam t_step UC_EXC_CODE    = 5'd8;
    localparam t_step UC_RD_FC       = 5'd9;
    localparam t_step UC_RD_BCNT     = 5'd10;
    localparam t_step UC_RD_HI       = 5'd11;
    localparam t_step UC_RD_LO       = 5'd12;
    localparam t_step UC_WR_FC       = 5'd13;
    localparam t_step UC_WR_REG_HI   = 5'd14;
    localparam t_step UC_WR_REG_LO   = 5'd15;
    localparam t_step UC_WR_VAL_HI   = 5'd16;
    localparam t_step UC_WR_VAL_LO   = 5'd17;

    // Frame byte positions.
    localparam t_step FB_TID_HI = 5'd0;
    localparam t_step FB_TID_LO = 5'd1;
    localparam t_step FB_UNIT   = 5'd6;
    localparam t_step FB_REG_HI = 5'd8;
    localparam t_step FB_REG_LO = 5'd9;
    localparam t_step FB_VAL_HI = 5'd10;
    localparam t_step FB_VAL_LO = 5'd11;

    // Byte source selected by a control word.
    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_FRAME,
        SRC_LEN,
        SRC_EXC_FC,
        SRC_EXC_CODE,
        SRC_READ_FC,
        SRC_WRITE_FC,
        SRC_BCNT,
        SRC_WORD_HI,
        SRC_WORD_LO
    } t_src;

    // Sequencing action of a control word.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_END,
        COND_DISPATCH,
        COND_END_IF_EMPTY,
        COND_LOOP
    } t_cond;

    typedef struct packed {
        t_src  src;
        t_cond cond;
        t_step arg;     // frame byte index or jump target
    } t_ucode;

    typedef enum logic [1:0] {
        KIND_EXC,
        KIND_READ,
        KIND_WRITE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN
    } t_state;

    typedef struct packed {
        logic [KEPT_BYTES-1:0][7:0] bytes;
        logic                       long_enough;
    } t_frame_info;

endpackage

`default_nettype wire

@@ hw/rtl/mbtcp_rr_ucode_rom.sv @@
// ----------------------------------------------------------------------------
// Modbus TCP responder microcode ROM
// One control word per response step: byte source, sequencing action, argument.
// ----------------------------------------------------------------------------
`default_nettype none

module mbtcp_rr_ucode_rom
    import mbtcp_rr_pkg::*;
(
    input  wire t_step  i_step,
    output t_ucode      o_word
);

    always_comb begin
        case (i_step)
            UC_TID_HI:    o_word = '{src: SRC_FRAME,    cond: COND_NEXT,     arg: FB_TID_HI};
            UC_TID_LO:    o_word = '{src: SRC_FRAME,    cond: COND_NEXT,     arg: FB_TID_LO};
            UC_PID_HI:    o_word = '{src: SRC_ZERO,     cond: COND_NEXT,     arg: '0};
            UC_PID_LO:    o_word = '{src: SRC_ZERO,     cond: COND_NEXT,     arg: '0};
            UC_LEN_HI:    o_word = '{src: SRC_ZERO,     cond: COND_NEXT,     arg: '0};
            UC_LEN_LO:    o_word = '{src: SRC_LEN,      cond: COND_NEXT,     arg: '0};
            UC_UNIT:      o_word = '{src: SRC_FRAME,    cond: COND_DISPATCH, arg: FB_UNIT};
            UC_EXC_FC:    o_word = '{src: SRC_EXC_FC,   cond: COND_NEXT,     arg: '0};
            UC_EXC_CODE:  o_word = '{src: SRC_EXC_CODE, cond: COND_END,      arg: '0};
            UC_RD_FC:     o_word = '{src: SRC_READ_FC,  cond: COND_NEXT,     arg: '0};
            UC_RD_BCNT:   o_word = '{src: SRC_BCNT,     cond: COND_END_IF_EMPTY, arg: '0};
            UC_RD_HI:     o_word = '{src: SRC_WORD_HI,  cond: COND_NEXT,     arg: '0};
            UC_RD_LO:     o_word = '{src: SRC_WORD_LO,  cond: COND_LOOP,     arg: UC_RD_HI};
            UC_WR_FC:     o_word = '{src: SRC_WRITE_FC, cond: COND_NEXT,     arg: '0};
            UC_WR_REG_HI: o_word = '{src: SRC_FRAME,    cond: COND_NEXT,     arg: FB_REG_HI};
            UC_WR_REG_LO: o_word = '{src: SRC_FRAME,    cond: COND_NEXT,     arg: FB_REG_LO};
            UC_WR_VAL_HI: o_word = '{src: SRC_FRAME,    cond: COND_NEXT,     arg: FB_VAL_HI};
            UC_WR_VAL_LO: o_word = '{src: SRC_FRAME,    cond: COND_END,      arg: FB_VAL_LO};
            default:      o_word = '{src: SRC_ZERO,     cond: COND_END,      arg: '0};
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/mbtcp_rr_frame.sv @@
// ----------------------------------------------------------------------------
// Modbus TCP responder frame store
// Holds the first request bytes, the byte count and the telemetry bank.
// ----------------------------------------------------------------------------
`default_nettype none

module mbtcp_rr_frame
    import mbtcp_rr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 260
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_byte_we,
    input  wire [7:0]               i_byte,
    input  wire                     i_clear,
    input  wire                     i_tele_we,
    input  wire [TELE_IDX_W-1:0]    i_tele_index,
    input  wire [15:0]              i_tele_word,
    input  wire [READ_ADDR_W-1:0]   i_rd_addr,
    output logic [15:0]             o_rd_word,
    output t_frame_info             o_info
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_KEPT = POS_W'(KEPT_BYTES);
    localparam logic [POS_W-1:0] POS_MIN  = POS_W'(MIN_FRAME_BYTES);

    logic [KEPT_BYTES-1:0][7:0] r_bytes;
    logic [POS_W-1:0]           r_pos;
    logic [TELE_WORDS-1:0][15:0] r_bank;

    // Bytes past the kept window are only counted; the count saturates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bytes <= '0;
            r_pos   <= '0;
        end else if (i_byte_we) begin
            if (r_pos < POS_KEPT) begin
                r_bytes[r_pos[KEPT_IDX_W-1:0]] <= i_byte;
            end
            if (r_pos < POS_MAX) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= '0;
        end else if (i_tele_we &&
                     ({1'b0, i_tele_index} < (TELE_IDX_W + 1)'(TELE_WORDS))) begin
            r_bank[i_tele_index] <= i_tele_word;
        end
    end

    // Addresses outside the bank read as zero; the address never wraps.
    assign o_rd_word = (i_rd_addr < READ_ADDR_W'(TELE_WORDS))
                       ? r_bank[i_rd_addr[TELE_IDX_W-1:0]] : 16'd0;

    assign o_info.bytes       = r_bytes;
    assign o_info.long_enough = (r_pos >= POS_MIN);

endmodule

`default_nettype wire

@@ hw/rtl/modbus_tcp_register_responder_top.sv @@
// ----------------------------------------------------------------------------
// Modbus TCP register responder
// Answers read holding registers and write single register requests from a
// byte stream, with a telemetry bank updated through the same input channel.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Contents
// s_axis    in   tvalid / tready         request byte or telemetry update
// m_axis    out  tvalid / tready         one response byte per transfer
// cfg       in   i_cfg_we (no wait)      unit address, setpoint address
//
// Request bytes and telemetry updates are taken one per cycle while the block
// is idle. The last byte of a frame leads to a check state, after which the
// microcode sequencer emits one response byte per cycle from its output
// register while m_axis_tready allows (9 to 9 + 2 * MAX_READ_WORDS bytes
// per response); the input stays stalled until the last response byte has
// been loaded into the output register. A stalled m_axis_tready holds the
// sequencer on its current step. Reset is synchronous and active low; it
// clears the frame store, the telemetry bank and the configuration registers
// to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_tcp_register_responder_top
    import mbtcp_rr_pkg::*;
#(
    parameter int MAX_READ_WORDS  = 10,
    parameter int MAX_FRAME_BYTES = 260
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [10:8] tele_index, [26:11] tele_word, [31:27] zero
    input  wire [31:0]  s_axis_tdata,
    // [0] func: 0 request byte, 1 telemetry update
    input  wire [0:0]   s_axis_tuser,
    input  wire         s_axis_tlast,

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] resp_byte, [23:8] power_value
    output logic [23:0] m_axis_tdata,
    // [0] power_update
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,

    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data
);

    localparam int WCNT_W = $clog2(MAX_READ_WORDS + 1);

    // Configuration registers.
    logic [7:0]  r_unit_address;
    logic [15:0] r_setpoint_address;

    // Sequencer state.
    t_state r_state, n_state;
    t_step  r_step,  n_step;

    // Per-response values latched during the check cycle.
    t_kind              r_kind,      n_kind;
    logic [7:0]         r_len,       n_len;
    logic [7:0]         r_exc_fc,    n_exc_fc;
    logic [7:0]         r_exc_code,  n_exc_code;
    logic [WCNT_W-1:0]  r_words,     n_words;
    logic [WCNT_W-1:0]  r_word_cnt,  n_word_cnt;
    logic [READ_ADDR_W-1:0] r_addr,  n_addr;
    logic               r_pflag,     n_pflag;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_resp_byte, n_resp_byte;
    logic        r_resp_last, n_resp_last;
    logic        r_power_update, n_power_update;
    logic [15:0] r_power_value,  n_power_value;

    logic        s_fire;
    logic        byte_we;
    logic        tele_we;
    logic        clear;
    t_frame_info info;
    logic [15:0] rd_word;
    t_ucode      uc;

    // Request fields decoded from the frame store.
    logic [7:0]  fc;
    logic [7:0]  unit;
    logic [15:0] dlen;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        frame_ok;
    logic [7:0]  sel_byte;
    logic        step_last;
    logic        out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign byte_we       = s_fire && !s_axis_tuser[0];
    assign tele_we       = s_fire &&  s_axis_tuser[0];

    mbtcp_rr_frame #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_we    (byte_we),
        .i_byte       (s_axis_tdata[7:0]),
        .i_clear      (clear),
        .i_tele_we    (tele_we),
        .i_tele_index (s_axis_tdata[10:8]),
        .i_tele_word  (s_axis_tdata[26:11]),
        .i_rd_addr    (r_addr),
        .o_rd_word    (rd_word),
        .o_info       (info)
    );

    mbtcp_rr_ucode_rom u_rom (
        .i_step (r_step),
        .o_word (uc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_address     <= UNIT_ADDRESS_RESET;
            r_setpoint_address <= SETPOINT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UNIT_ADDRESS:     r_unit_address     <= i_cfg_data[7:0];
                CFG_SETPOINT_ADDRESS: r_setpoint_address <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // MBAP header and PDU fields; bytes never received read as zero.
    assign unit   = info.bytes[6];
    assign fc     = info.bytes[7];
    assign dlen   = {info.bytes[4], info.bytes[5]};
    assign word_a = {info.bytes[8], info.bytes[9]};
    assign word_b = {info.bytes[10], info.bytes[11]};
    assign frame_ok = info.long_enough &&
                      (info.bytes[2] == 8'd0) && (info.bytes[3] == 8'd0) &&
                      ((unit == r_unit_address) || (unit == 8'd0));

    // Byte selected by the current control word.
    always_comb begin
        case (uc.src)
            SRC_ZERO:     sel_byte = 8'd0;
            SRC_FRAME:    sel_byte = info.bytes[uc.arg[KEPT_IDX_W-1:0]];
            SRC_LEN:      sel_byte = r_len;
            SRC_EXC_FC:   sel_byte = r_exc_fc;
            SRC_EXC_CODE: sel_byte = r_exc_code;
            SRC_READ_FC:  sel_byte = FC_READ_HOLDING;
            SRC_WRITE_FC: sel_byte = FC_WRITE_SINGLE;
            SRC_BCNT:     sel_byte = 8'({r_words, 1'b0});
            SRC_WORD_HI:  sel_byte = rd_word[15:8];
            SRC_WORD_LO:  sel_byte = rd_word[7:0];
            default:      sel_byte = 8'd0;
        endcase
    end

    always_comb begin
        case (uc.cond)
            COND_END:          step_last = 1'b1;
            COND_END_IF_EMPTY: step_last = (r_words == '0);
            COND_LOOP:         step_last = (WCNT_W'(r_word_cnt + 1'b1) == r_words);
            default:           step_last = 1'b0;
        endcase
    end

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_kind         = r_kind;
        n_len          = r_len;
        n_exc_fc       = r_exc_fc;
        n_exc_code     = r_exc_code;
        n_words        = r_words;
        n_word_cnt     = r_word_cnt;
        n_addr         = r_addr;
        n_pflag        = r_pflag;
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_resp_byte    = r_resp_byte;
        n_resp_last    = r_resp_last;
        n_power_update = r_power_update;
        n_power_value  = r_power_value;
        clear          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (byte_we && s_axis_tlast) begin
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                n_step     = UC_TID_HI;
                n_word_cnt = '0;
                n_addr     = {1'b0, word_a};
                n_pflag    = 1'b0;
                n_words    = '0;
                n_kind     = KIND_EXC;
                n_len      = LEN_EXCEPTION;
                n_exc_fc   = fc | FC_EXC_FLAG;
                n_exc_code = EXC_ILLEGAL_FUNC;
                if (fc == FC_READ_HOLDING) begin
                    n_exc_fc = FC_EXC_READ;
                    if (dlen < MIN_DATA_LEN) begin
                        n_exc_code = EXC_ILLEGAL_ADDR;
                    end else if (word_b > READ_COUNT_LIMIT) begin
                        n_exc_code = EXC_ILLEGAL_DATA;
                    end else begin
                        n_kind = KIND_READ;
                        // Reads are truncated to MAX_READ_WORDS words.
                        if (word_b < 16'(MAX_READ_WORDS)) begin
                            n_words = WCNT_W'(word_b);
                        end else begin
                            n_words = WCNT_W'(MAX_READ_WORDS);
                        end
                        n_len = LEN_READ_BASE + 8'({n_words, 1'b0});
                    end
                end else if (fc == FC_WRITE_SINGLE) begin
                    n_exc_fc = FC_EXC_WRITE;
                    if (dlen < MIN_DATA_LEN) begin
                        n_exc_code = EXC_ILLEGAL_ADDR;
                    end else begin
                        n_kind  = KIND_WRITE;
                        n_len   = LEN_WRITE;
                        n_pflag = (word_a == r_setpoint_address);
                    end
                end
                if (frame_ok) begin
                    n_state = S_RUN;
                end else begin
                    // Rejected frames are dropped silently.
                    clear   = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_RUN: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_resp_byte    = sel_byte;
                    n_resp_last    = step_last;
                    n_power_update = step_last && r_pflag;
                    n_power_value  = (step_last && r_pflag) ? word_b : 16'd0;
                    if (step_last) begin
                        clear   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        case (uc.cond)
                            COND_DISPATCH: begin
                                case (r_kind)
                                    KIND_READ:  n_step = UC_RD_FC;
                                    KIND_WRITE: n_step = UC_WR_FC;
                                    default:    n_step = UC_EXC_FC;
                                endcase
                            end
                            COND_LOOP: begin
                                n_step     = uc.arg;
                                n_word_cnt = r_word_cnt + 1'b1;
                                n_addr     = r_addr + 1'b1;
                            end
                            default: n_step = r_step + 1'b1;
                        endcase
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= UC_TID_HI;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind         <= n_kind;
        r_len          <= n_len;
        r_exc_fc       <= n_exc_fc;
        r_exc_code     <= n_exc_code;
        r_words        <= n_words;
        r_word_cnt     <= n_word_cnt;
        r_addr         <= n_addr;
        r_pflag        <= n_pflag;
        r_resp_byte    <= n_resp_byte;
        r_resp_last    <= n_resp_last;
        r_power_update <= n_power_update;
        r_power_value  <= n_power_value;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_power_value, r_resp_byte};
    assign m_axis_tuser  = r_power_update;
    assign m_axis_tlast  = r_resp_last;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus TCP register responder testbench
// Streams request frames and telemetry updates into the responder and checks
// every response transfer against a behavioral model kept in step with the
// stimulus, across several unit and setpoint address settings.
// ----------------------------------------------------------------------------

module testbench;
    import mbtcp_rr_pkg::*;

    // Meaning of s_axis_tuser[0].
    localparam logic FUNC_REQUEST   = 1'b0;
    localparam logic FUNC_TELEMETRY = 1'b1;

    // Frame byte offsets that the package does not name.
    localparam int FB_PID  = 2;
    localparam int FB_LEN  = 4;
    localparam int FB_FUNC = 7;

    // Block geometry used by the model.
    localparam int READ_WORD_CAP  = 10;
    localparam int FRAME_POS_SAT  = 260;

    // Function codes the responder does not support.
    localparam logic [7:0] FC_NONE    = 8'h00;
    localparam logic [7:0] FC_ALL_ONE = 8'hFF;

    // Filler for request bytes past the stored header.
    localparam logic [7:0] FILL_BYTE = 8'hA5;

    // Cycles to let the block settle before a register write and at the end.
    localparam int SETTLE_CYCLES = 40;
    // Random input transfers per register setting.
    localparam int PHASE_ITEMS   = 50;
    // Printed mismatch lines are capped; every mismatch is still counted.
    localparam int PRINT_CAP     = 40;

    // One response transfer as the model predicts it.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        power_update;
        logic [15:0] power_value;
    } reply_beat_t;

    typedef enum int {ROW_TELE, ROW_FRAME} row_kind_t;
    typedef enum int {CHK_MODEL, CHK_SILENT, CHK_EXCEPTION} row_check_t;

    // One row of the directed table: a telemetry update or a whole request frame.
    typedef struct {
        row_kind_t   kind;
        int          len;
        logic [95:0] head;      // request bytes 0 to 11, byte 0 in the top bits
        int          tele_at;   // byte position before which an update is slipped in
        logic [2:0]  tele_idx;
        logic [15:0] tele_word;
        row_check_t  check;
        logic [7:0]  exc_fc;
        logic [7:0]  exc_code;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Block interface.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        s_axis_tlast;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;
    wire  [0:0]  m_axis_tuser;
    wire         m_axis_tlast;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    modbus_tcp_register_responder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Responder model. It mirrors the configuration, the frame store, the
    // byte counter and the telemetry bank, and turns the last byte of each
    // frame into the list of response transfers that the block must send.
    // ------------------------------------------------------------------------
    logic [7:0]  mdl_unit;
    logic [15:0] mdl_setpoint;
    logic [7:0]  mdl_frame [KEPT_BYTES];
    int          mdl_pos;
    logic [15:0] mdl_bank [TELE_WORDS];

    reply_beat_t last_reply [$];     // response of the frame just closed
    reply_beat_t pending_reply [$];  // response transfers still to arrive
    logic        defer_reply = 1'b0; // directed rows supply their own answer

    int error_count  = 0;
    int items_sent   = 0;
    int frames_sent  = 0;
    int updates_sent = 0;
    int beats_seen   = 0;
    int reg_writes   = 0;
    int burst_left   = 0;

    function automatic logic [15:0] frame_word(int pos);
        return {mdl_frame[pos], mdl_frame[pos + 1]};
    endfunction

    function automatic void clear_frame();
        foreach (mdl_frame[i]) mdl_frame[i] = 8'h00;
        mdl_pos = 0;
    endfunction

    function automatic void reset_model();
        mdl_unit     = UNIT_ADDRESS_RESET;
        mdl_setpoint = SETPOINT_RESET;
        foreach (mdl_bank[i]) mdl_bank[i] = 16'h0000;
        clear_frame();
        last_reply.delete();
    endfunction

    // Builds the response to the frame held in the store. Frames that are too
    // short, carry a nonzero protocol id or address another unit get none.
    function automatic void build_reply();
        logic [7:0]  rb [$];
        logic [7:0]  unit_id;
        logic [7:0]  fcode;
        logic [15:0] dlen;
        logic [15:0] field_a;
        logic [15:0] field_b;
        logic [16:0] addr;
        logic [15:0] word;
        logic        flag;
        int          words;
        int          n;
        reply_beat_t beat;
        unit_id = mdl_frame[FB_UNIT];
        fcode   = mdl_frame[FB_FUNC];
        dlen    = frame_word(FB_LEN);
        field_a = frame_word(FB_REG_HI);
        field_b = frame_word(FB_VAL_HI);
        flag    = 1'b0;
        last_reply.delete();
        if (mdl_pos < MIN_FRAME_BYTES || frame_word(FB_PID) != 16'd0) return;
        if (unit_id != mdl_unit && unit_id != 8'd0) return;

        rb.push_back(mdl_frame[FB_TID_HI]);
        rb.push_back(mdl_frame[FB_TID_LO]);
        repeat (4) rb.push_back(8'h00);
        rb.push_back(unit_id);

        if (fcode == FC_READ_HOLDING && dlen < MIN_DATA_LEN) begin
            rb.push_back(FC_EXC_READ);
            rb.push_back(EXC_ILLEGAL_ADDR);
        end else if (fcode == FC_READ_HOLDING && field_b > READ_COUNT_LIMIT) begin
            rb.push_back(FC_EXC_READ);
            rb.push_back(EXC_ILLEGAL_DATA);
        end else if (fcode == FC_READ_HOLDING) begin
            // Counts above the cap are cut down, and the byte count follows.
            words = (field_b < READ_WORD_CAP) ? int'(field_b) : READ_WORD_CAP;
            rb.push_back(FC_READ_HOLDING);
            rb.push_back(8'(2 * words));
            for (int i = 0; i < words; i++) begin
                // The address is 17 bits wide so that it never wraps to zero.
                addr = {1'b0, field_a} + 17'(i);
                word = (addr < TELE_WORDS) ? mdl_bank[addr[TELE_IDX_W-1:0]] : 16'h0000;
                rb.push_back(word[15:8]);
                rb.push_back(word[7:0]);
            end
        end else if (fcode == FC_WRITE_SINGLE && dlen < MIN_DATA_LEN) begin
            rb.push_back(FC_EXC_WRITE);
            rb.push_back(EXC_ILLEGAL_ADDR);
        end else if (fcode == FC_WRITE_SINGLE) begin
            flag = (field_a == mdl_setpoint);
            rb.push_back(FC_WRITE_SINGLE);
            rb.push_back(field_a[15:8]);
            rb.push_back(field_a[7:0]);
            rb.push_back(field_b[15:8]);
            rb.push_back(field_b[7:0]);
        end else begin
            rb.push_back(fcode | FC_EXC_FLAG);
            rb.push_back(EXC_ILLEGAL_FUNC);
        end

        n = rb.size() - 6;
        rb[4] = 8'(n >> 8);
        rb[5] = 8'(n);
        foreach (rb[k]) begin
            beat.data         = rb[k];
            beat.last         = (k == rb.size() - 1);
            beat.power_update = beat.last && flag;
            beat.power_value  = beat.power_update ? field_b : 16'h0000;
            last_reply.push_back(beat);
        end
    endfunction

    // Applies one accepted input transfer to the model.
    function automatic void model_accept(input logic func, input logic [7:0] data_byte,
                                         input logic frame_end, input logic [2:0] idx,
                                         input logic [15:0] word);
        last_reply.delete();
        if (func == FUNC_TELEMETRY) begin
            // Updates land in the bank without touching a frame in progress.
            mdl_bank[idx] = word;
            return;
        end
        if (mdl_pos < KEPT_BYTES) mdl_frame[mdl_pos] = data_byte;
        if (mdl_pos < FRAME_POS_SAT) mdl_pos++;
        if (frame_end) begin
            build_reply();
            clear_frame();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Inputs change on the falling edge; a transfer completes at the
    // rising edge where tvalid and tready are both high. Transfers come in
    // bursts of random length, separated by random gaps of idle cycles.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic func, input logic [7:0] data_byte,
                             input logic frame_end, input logic [2:0] idx,
                             input logic [15:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            // Now and then a long burst runs with no gaps at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b00000, word, idx, data_byte};
        s_axis_tuser  = func;
        s_axis_tlast  = frame_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        // Accepted at this edge; the model and the expectations follow at once,
        // before the first response transfer can appear.
        burst_left--;
        items_sent++;
        if (func == FUNC_TELEMETRY) updates_sent++;
        else if (frame_end) frames_sent++;
        model_accept(func, data_byte, frame_end, idx, word);
        if (!defer_reply) begin
            foreach (last_reply[k]) pending_reply.push_back(last_reply[k]);
        end
    endtask

    // Telemetry update; the request byte and frame end fields carry noise.
    task automatic send_update(input logic [2:0] idx, input logic [15:0] word);
        send_item(FUNC_TELEMETRY, 8'($urandom), 1'($urandom), idx, word);
    endtask

    // Sends one frame; an update may be slipped in before byte tele_at.
    task automatic send_frame(input logic [7:0] fb [$], input int tele_at,
                              input logic [2:0] idx, input logic [15:0] word);
        foreach (fb[i]) begin
            if (i == tele_at) send_update(idx, word);
            send_item(FUNC_REQUEST, fb[i], i == fb.size() - 1, 3'($urandom), 16'($urandom));
        end
    endtask

    // Lowers tvalid and waits until every expected response has arrived,
    // then lets the block finish the check cycle of a frame that had none.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_reply.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Configuration write; only called while the block is idle.
    task automatic write_reg(input logic [0:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        reg_writes++;
        if (index == CFG_UNIT_ADDRESS) mdl_unit = value[7:0];
        else mdl_setpoint = value;
    endtask

    // ------------------------------------------------------------------------
    // Random frames. Most are well formed with random content so that reads
    // and writes reach their data paths; the rest break the header, cut the
    // frame short, pad it out or are plain noise.
    // ------------------------------------------------------------------------
    task automatic send_random_frame();
        logic [7:0]  fb [$];
        logic [15:0] tid;
        logic [15:0] pid;
        logic [15:0] dlen;
        logic [15:0] field_a;
        logic [15:0] field_b;
        logic [7:0]  unit_id;
        logic [7:0]  fcode;
        int          pick;
        int          len;
        int          tele_at;
        tid = 16'($urandom);
        pid = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;

        pick = $urandom_range(0, 15);
        if (pick == 0) dlen = 16'($urandom_range(0, 3));
        else if (pick == 1) dlen = 16'($urandom);
        else dlen = 16'd6;

        pick = $urandom_range(0, 9);
        if (pick < 6) unit_id = mdl_unit;
        else if (pick < 8) unit_id = 8'h00;
        else if (pick == 8) unit_id = mdl_unit + 8'd1;
        else unit_id = 8'($urandom);

        pick = $urandom_range(0, 9);
        if (pick < 5) fcode = FC_READ_HOLDING;
        else if (pick < 8) fcode = FC_WRITE_SINGLE;
        else fcode = 8'($urandom);

        if (fcode == FC_WRITE_SINGLE) begin
            field_a = ($urandom_range(0, 1) == 0) ? mdl_setpoint : 16'($urandom);
            field_b = 16'($urandom);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) field_a = 16'($urandom_range(0, 7));
            else if (pick < 8) field_a = 16'($urandom_range(65526, 65535));
            else field_a = 16'($urandom);
            pick = $urandom_range(0, 19);
            if (pick < 15) field_b = 16'($urandom_range(0, 12));
            else if (pick < 19) field_b = 16'($urandom_range(13, 25));
            else field_b = 16'($urandom);
        end

        fb = {tid[15:8], tid[7:0], pid[15:8], pid[7:0], dlen[15:8], dlen[7:0],
              unit_id, fcode, field_a[15:8], field_a[7:0], field_b[15:8], field_b[7:0]};

        pick = $urandom_range(0, 19);
        if (pick < 14) len = KEPT_BYTES;
        else if (pick < 16) len = $urandom_range(MIN_FRAME_BYTES, KEPT_BYTES - 1);
        else if (pick < 18) len = $urandom_range(KEPT_BYTES + 1, 24);
        else if (pick == 18) len = $urandom_range(1, MIN_FRAME_BYTES - 1);
        else begin
            // Noise: every byte random.
            len = $urandom_range(1, 16);
            foreach (fb[i]) fb[i] = 8'($urandom);
        end
        while (fb.size() > len) void'(fb.pop_back());
        while (fb.size() < len) fb.push_back(8'($urandom));

        tele_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
        send_frame(fb, tele_at, 3'($urandom), 16'($urandom));
    endtask

    task automatic random_phase(input int target);
        int first;
        first = items_sent;
        while (items_sent - first < target) begin
            if ($urandom_range(0, 4) == 0) send_update(3'($urandom), 16'($urandom));
            else send_random_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. tready follows a pattern of its own: it switches at random
    // between always ready, mostly ready, a fixed one-in-three stall and long
    // stalls.
    // ------------------------------------------------------------------------
    int ready_mode  = 0;
    int ready_left  = 0;
    int ready_phase = 0;

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 120);
        end else begin
            ready_left--;
        end
        ready_phase = (ready_phase == 2) ? 0 : ready_phase + 1;
        case (ready_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = ($urandom_range(0, 3) != 0);
            2: m_axis_tready = (ready_phase != 0);
            default: m_axis_tready = ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Checker. Each response transfer is compared field by field with the
    // oldest pending expectation.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t ns: mismatch in %s after %0d response transfers: got %h, expected %h",
                     $time, what, beats_seen, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        reply_beat_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reply.size() == 0) begin
                report_mismatch("unexpected response transfer", {8'h00, m_axis_tdata[7:0]},
                                16'h0000);
            end else begin
                want = pending_reply.pop_front();
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch("resp_byte", {8'h00, m_axis_tdata[7:0]}, {8'h00, want.data});
                if (m_axis_tlast !== want.last)
                    report_mismatch("resp_last", 16'(m_axis_tlast), 16'(want.last));
                if (m_axis_tuser[0] !== want.power_update)
                    report_mismatch("power_update", 16'(m_axis_tuser[0]), 16'(want.power_update));
                if (m_axis_tdata[23:8] !== want.power_value)
                    report_mismatch("power_value", m_axis_tdata[23:8], want.power_value);
            end
            beats_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table helpers.
    // ------------------------------------------------------------------------
    function automatic logic [95:0] mbap(input logic [15:0] tid, input logic [15:0] dlen,
                                         input logic [7:0] unit_id, input logic [7:0] fcode,
                                         input logic [15:0] field_a, input logic [15:0] field_b);
        return {tid, 16'h0000, dlen, unit_id, fcode, field_a, field_b};
    endfunction

    function automatic stim_row_t frame_row(input int len, input logic [95:0] head,
                                            input row_check_t chk,
                                            input logic [7:0] efc = 8'h00,
                                            input logic [7:0] ecode = 8'h00);
        stim_row_t row;
        row.kind      = ROW_FRAME;
        row.len       = len;
        row.head      = head;
        row.tele_at   = -1;
        row.tele_idx  = 3'd0;
        row.tele_word = 16'h0000;
        row.check     = chk;
        row.exc_fc    = efc;
        row.exc_code  = ecode;
        return row;
    endfunction

    function automatic stim_row_t tele_row(input logic [2:0] idx, input logic [15:0] word);
        stim_row_t row;
        row           = frame_row(0, 96'h0, CHK_MODEL);
        row.kind      = ROW_TELE;
        row.tele_idx  = idx;
        row.tele_word = word;
        return row;
    endfunction

    stim_row_t stim_rows [$];

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table under the reset configuration,
    // then random traffic under several register settings, the extremes first.
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  fb [$];
        logic [7:0]  exc_bytes [9];
        reply_beat_t beat;
        stim_row_t   row;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'h0;
        s_axis_tuser  = FUNC_REQUEST;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_UNIT_ADDRESS;
        i_cfg_data    = 16'h0000;
        i_rst_n       = 1'b0;
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Bank extremes first, so reads show every bit in both states.
        stim_rows.push_back(tele_row(3'd0, 16'hFFFF));
        stim_rows.push_back(tele_row(3'd7, 16'h8001));
        stim_rows.push_back(tele_row(3'd3, 16'h1234));
        // Reads: whole bank, a count cut to the cap, an oversized count, an
        // empty read, a read that runs off the top of the address space and
        // one whose declared length is too short.
        stim_rows.push_back(frame_row(12, mbap(16'h0001, 6, 1, FC_READ_HOLDING, 0, 8),
                                      CHK_MODEL));
        stim_rows.push_back(frame_row(12, mbap(16'hFFFF, 6, 1, FC_READ_HOLDING, 0, 20),
                                      CHK_MODEL));
        stim_rows.push_back(frame_row(12, mbap(16'h0002, 6, 1, FC_READ_HOLDING, 0, 21),
                                      CHK_EXCEPTION, FC_EXC_READ, EXC_ILLEGAL_DATA));
        stim_rows.push_back(frame_row(12, mbap(16'h0003, 6, 1, FC_READ_HOLDING, 5, 0),
                                      CHK_MODEL));
        stim_rows.push_back(frame_row(12, mbap(16'h0004, 6, 1, FC_READ_HOLDING, 16'hFFFF, 10),
                                      CHK_MODEL));
        stim_rows.push_back(frame_row(12, mbap(16'h0005, 3, 1, FC_READ_HOLDING, 0, 1),
                                      CHK_EXCEPTION, FC_EXC_READ, EXC_ILLEGAL_ADDR));
        // Writes: to the setpoint, next to it, and with a short declared length.
        stim_rows.push_back(frame_row(12, mbap(16'h0006, 6, 1, FC_WRITE_SINGLE,
                                               SETPOINT_RESET, 16'hBEEF), CHK_MODEL));
        stim_rows.push_back(frame_row(12, mbap(16'h0007, 6, 1, FC_WRITE_SINGLE,
                                               SETPOINT_RESET + 16'd1, 16'h0000), CHK_MODEL));
        stim_rows.push_back(frame_row(12, mbap(16'h0008, 0, 1, FC_WRITE_SINGLE,
                                               SETPOINT_RESET, 16'h0001),
                                      CHK_EXCEPTION, FC_EXC_WRITE, EXC_ILLEGAL_ADDR));
        // Unsupported function codes, the lowest and the highest.
        stim_rows.push_back(frame_row(8, mbap(16'h0009, 2, 1, FC_NONE, 0, 0),
                                      CHK_EXCEPTION, FC_NONE | FC_EXC_FLAG, EXC_ILLEGAL_FUNC));
        stim_rows.push_back(frame_row(8, mbap(16'h000A, 2, 1, FC_ALL_ONE, 0, 0),
                                      CHK_EXCEPTION, FC_ALL_ONE | FC_EXC_FLAG, EXC_ILLEGAL_FUNC));
        // Frames that are dropped: too short, bad protocol id, another unit.
        stim_rows.push_back(frame_row(7, mbap(16'h000B, 6, 1, FC_READ_HOLDING, 0, 1),
                                      CHK_SILENT));
        stim_rows.push_back(frame_row(12, {16'h000C, 16'h0001, 16'd6, 8'd1, FC_READ_HOLDING,
                                           16'd0, 16'd1}, CHK_SILENT));
        stim_rows.push_back(frame_row(12, mbap(16'h000D, 6, 5, FC_READ_HOLDING, 0, 1),
                                      CHK_SILENT));
        // Broadcast unit id is answered.
        stim_rows.push_back(frame_row(12, mbap(16'h000E, 6, 0, FC_READ_HOLDING, 3, 2),
                                      CHK_MODEL));
        // Missing bytes read as zero: the write lands on register zero.
        stim_rows.push_back(frame_row(9, mbap(16'h000F, 6, 1, FC_WRITE_SINGLE,
                                              SETPOINT_RESET, 16'h7777), CHK_MODEL));
        // Long frame: bytes past the stored header are counted but not kept.
        stim_rows.push_back(frame_row(24, mbap(16'h0010, 6, 1, FC_WRITE_SINGLE,
                                               SETPOINT_RESET, 16'h0001), CHK_MODEL));
        // A telemetry update in the middle of a read of the same word.
        row = frame_row(12, mbap(16'h0011, 6, 1, FC_READ_HOLDING, 3, 1), CHK_MODEL);
        row.tele_at   = 6;
        row.tele_idx  = 3'd3;
        row.tele_word = 16'hCAFE;
        stim_rows.push_back(row);

        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            if (row.kind == ROW_TELE) begin
                send_update(row.tele_idx, row.tele_word);
            end else begin
                fb.delete();
                for (int i = 0; i < row.len; i++) begin
                    if (i < KEPT_BYTES) fb.push_back(row.head[95 - 8 * i -: 8]);
                    else fb.push_back(FILL_BYTE);
                end
                defer_reply = (row.check != CHK_MODEL);
                send_frame(fb, row.tele_at, row.tele_idx, row.tele_word);
                defer_reply = 1'b0;
                // Exception answers are short enough to spell out here.
                if (row.check == CHK_EXCEPTION) begin
                    exc_bytes = '{row.head[95:88], row.head[87:80], 8'h00, 8'h00, 8'h00,
                                  LEN_EXCEPTION, row.head[47:40], row.exc_fc, row.exc_code};
                    foreach (exc_bytes[k]) begin
                        beat.data         = exc_bytes[k];
                        beat.last         = (k == 8);
                        beat.power_update = 1'b0;
                        beat.power_value  = 16'h0000;
                        pending_reply.push_back(beat);
                    end
                end
            end
        end
        wait_drained();

        // Highest unit id and setpoint address.
        write_reg(CFG_UNIT_ADDRESS, 16'd247);
        write_reg(CFG_SETPOINT_ADDRESS, 16'hFFFF);
        random_phase(PHASE_ITEMS);
        wait_drained();

        // Lowest: only broadcast frames are answered, setpoint at zero.
        write_reg(CFG_UNIT_ADDRESS, 16'd0);
        write_reg(CFG_SETPOINT_ADDRESS, 16'h0000);
        random_phase(PHASE_ITEMS);
        wait_drained();

        // A random setting, with the setpoint inside the telemetry range.
        write_reg(CFG_UNIT_ADDRESS, 16'($urandom_range(1, 246)));
        write_reg(CFG_SETPOINT_ADDRESS, 16'($urandom_range(0, TELE_WORDS - 1)));
        random_phase(PHASE_ITEMS);
        wait_drained();

        // Back to the reset values.
        write_reg(CFG_UNIT_ADDRESS, 16'(UNIT_ADDRESS_RESET));
        write_reg(CFG_SETPOINT_ADDRESS, SETPOINT_RESET);
        random_phase(PHASE_ITEMS);
        wait_drained();

        $display("Sent %0d input transfers: %0d request frames and %0d telemetry updates.",
                 items_sent, frames_sent, updates_sent);
        $display("Checked %0d response transfers over %0d register writes; %0d mismatches.",
                 beats_seen, reg_writes, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d response transfers still pending.", pending_reply.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
